/* sv/pcp_pkg.sv */
// Package for the pitch cascade PID block: payload types, register indexes, constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pcp_pkg;

    typedef struct packed {
        logic signed [15:0] measured_angle;
        logic signed [15:0] target_angle;
        logic signed [15:0] rate_sample;
        logic        [15:0] elapsed_ticks;
    } pcp_in_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } pcp_out_t;

    typedef struct packed {
        logic signed [15:0] outer_kp;
        logic signed [15:0] outer_ki;
        logic signed [15:0] inner_kp;
        logic signed [15:0] inner_kd;
        logic signed [15:0] feedforward_gain;
        logic        [14:0] output_limit;
        logic        [14:0] separation_window;
    } pcp_cfg_t;

    localparam logic [2:0] REG_OUTER_KP   = 3'd0;
    localparam logic [2:0] REG_OUTER_KI   = 3'd1;
    localparam logic [2:0] REG_INNER_KP   = 3'd2;
    localparam logic [2:0] REG_INNER_KD   = 3'd3;
    localparam logic [2:0] REG_FF_GAIN    = 3'd4;
    localparam logic [2:0] REG_OUT_LIMIT  = 3'd5;
    localparam logic [2:0] REG_SEP_WINDOW = 3'd6;

    localparam int INTEGRAL_MAX = 3000;
    localparam int INTEGRAL_MIN = -2000;
    localparam int DIV_BITS     = 40;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic outer;
        logic inner_p;
        logic div_start;
        logic div_step;
        logic finish;
    } pcp_cmd_t;

    typedef struct packed {
        logic div_done;
    } pcp_sts_t;

endpackage
`default_nettype wire

/* sv/pcp_datapath.sv */
// Datapath of the pitch cascade PID: state, products and a serial divider.
// Depends on pcp_pkg; sequenced by pcp_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module pcp_datapath
    import pcp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire pcp_cfg_t cfg,
    input  wire pcp_in_t  in_item,
    input  wire pcp_cmd_t cmd,
    output pcp_sts_t      sts,
    output pcp_out_t      result
);

    logic signed [16:0] err_reg, err_next;
    logic signed [12:0] integ_reg, integ_next;
    logic signed [15:0] prev_tgt_reg, prev_rate_reg;
    logic signed [15:0] rate_reg, tgt_reg;
    logic        [15:0] ticks_reg;
    logic signed [33:0] outer_reg;
    logic signed [51:0] sum_reg;
    logic signed [33:0] pa_reg, pb_reg;
    logic        [DIV_BITS-1:0] quo_reg, rem_reg;
    logic        [5:0]  cnt_reg;
    logic               dneg_reg;

    logic signed [17:0] mag;
    logic signed [18:0] isum;
    logic signed [16:0] ddelta;
    logic signed [33:0] dprod;
    logic        [DIV_BITS-1:0] dabs;
    logic        [DIV_BITS:0]   trial;
    logic signed [33:0] outer_q;
    logic signed [34:0] rerr;
    logic signed [51:0] rp;
    logic signed [16:0] tdelta;
    logic signed [51:0] total, rawq;
    logic signed [16:0] lim;

    always_comb begin
        err_next = 17'(in_item.measured_angle) - 17'(in_item.target_angle);
        mag = err_next[16] ? -18'(err_next) : 18'(err_next);
        isum = 19'(integ_reg) + 19'(err_next);
        if (mag >= 18'(cfg.separation_window)) begin
            integ_next = '0;
        end else if (isum > 19'(INTEGRAL_MAX)) begin
            integ_next = 13'(INTEGRAL_MAX);
        end else if (isum < 19'(INTEGRAL_MIN)) begin
            integ_next = 13'(INTEGRAL_MIN);
        end else begin
            integ_next = 13'(isum);
        end
    end

    assign ddelta = 17'(prev_rate_reg) - 17'(rate_reg);
    assign dprod  = ddelta * cfg.inner_kd;
    assign dabs   = dprod[33] ? DIV_BITS'(-dprod) : DIV_BITS'(dprod);
    assign trial  = {rem_reg, quo_reg[DIV_BITS-1]} - {25'd0, ticks_reg};
    assign outer_q = (pa_reg + pb_reg) / 34'sd256;
    assign rerr   = 35'(rate_reg) - 35'(outer_reg);
    assign rp     = rerr * cfg.inner_kp;
    assign tdelta = 17'(tgt_reg) - 17'(prev_tgt_reg);
    assign total  = sum_reg + (dneg_reg ? -52'(quo_reg) : 52'(quo_reg));
    assign rawq   = total / 52'sd256;
    assign lim    = 17'(cfg.output_limit);
    assign sts.div_done = (cnt_reg == 6'(DIV_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_tgt_reg <= '0;
            prev_rate_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                err_reg <= err_next;
                integ_reg <= integ_next;
                rate_reg <= in_item.rate_sample;
                tgt_reg <= in_item.target_angle;
                ticks_reg <= (in_item.elapsed_ticks == 16'd0) ? 16'd1 : in_item.elapsed_ticks;
            end
            if (cmd.outer) begin
                pa_reg <= err_reg * cfg.outer_kp;
                pb_reg <= 34'(integ_reg * cfg.outer_ki);
            end
            if (cmd.inner_p) begin
                outer_reg <= outer_q;
                pa_reg <= 34'(tdelta * cfg.feedforward_gain);
            end
            if (cmd.div_start) begin
                sum_reg <= rp + 52'(pa_reg);
                quo_reg <= dabs;
                rem_reg <= '0;
                dneg_reg <= dprod[33];
                cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                if (!trial[DIV_BITS]) begin
                    rem_reg <= trial[DIV_BITS-1:0];
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DIV_BITS-2:0], quo_reg[DIV_BITS-1]};
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (cmd.finish) begin
                prev_tgt_reg <= tgt_reg;
                prev_rate_reg <= rate_reg;
                if (rawq > 52'(lim)) begin
                    result.drive <= 16'(lim);
                    result.saturated <= 1'b1;
                end else if (rawq < -52'(lim)) begin
                    result.drive <= 16'(-lim);
                    result.saturated <= 1'b1;
                end else begin
                    result.drive <= 16'(rawq);
                    result.saturated <= 1'b0;
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        integ_reg <= 13'(INTEGRAL_MAX) && integ_reg >= 13'(INTEGRAL_MIN))
        else $error("integral out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> cnt_reg < 6'(DIV_BITS))
        else $error("divider overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (result.drive <= 16'(lim) && result.drive >= 16'(-lim)))
        else $error("drive beyond limit");

endmodule
`default_nettype wire

/* sv/pcp_ctrl.sv */
// Controller of the pitch cascade PID: sequences load, products, division, output.
// Depends on pcp_pkg; drives pcp_datapath.
`timescale 1ns / 1ps
`default_nettype none
module pcp_ctrl
    import pcp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire pcp_sts_t sts,
    output pcp_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_OUTER = 6'b000010,
        ST_INNER = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == ST_IDLE) && (!mvalid_reg || m_ready);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER: begin
                cmd.outer = 1'b1;
                state_next = ST_INNER;
            end
            ST_INNER: begin
                cmd.inner_p = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                mvalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (!mvalid_reg || m_ready))
        else $error("result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_OUTER))
        else $error("load not followed by outer step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |=> m_valid)
        else $error("result not presented");

endmodule
`default_nettype wire

/* sv/pitch_cascade_pid.sv */
// Top level of the pitch cascade PID: APB registers, controller and datapath.
// Depends on pcp_pkg, pcp_ctrl, pcp_datapath.
//
// One control tick per input transaction gives one drive transaction. A tick runs from
// acceptance to result through the gain products, then the 40-bit restoring divider that
// scales the rate derivative by the elapsed ticks, and last the saturation. The next
// tick is taken once the block is idle again and the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module pitch_cascade_pid
    import pcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire pcp_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output pcp_out_t         m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    pcp_cfg_t cfg_reg;
    pcp_cmd_t cmd;
    pcp_sts_t sts;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd5000, 15'd600};
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_OUTER_KP:   cfg_reg.outer_kp <= pwdata[15:0];
                REG_OUTER_KI:   cfg_reg.outer_ki <= pwdata[15:0];
                REG_INNER_KP:   cfg_reg.inner_kp <= pwdata[15:0];
                REG_INNER_KD:   cfg_reg.inner_kd <= pwdata[15:0];
                REG_FF_GAIN:    cfg_reg.feedforward_gain <= pwdata[15:0];
                REG_OUT_LIMIT:  cfg_reg.output_limit <= pwdata[14:0];
                REG_SEP_WINDOW: cfg_reg.separation_window <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_OUTER_KP:   prdata = {{16{cfg_reg.outer_kp[15]}}, cfg_reg.outer_kp};
            REG_OUTER_KI:   prdata = {{16{cfg_reg.outer_ki[15]}}, cfg_reg.outer_ki};
            REG_INNER_KP:   prdata = {{16{cfg_reg.inner_kp[15]}}, cfg_reg.inner_kp};
            REG_INNER_KD:   prdata = {{16{cfg_reg.inner_kd[15]}}, cfg_reg.inner_kd};
            REG_FF_GAIN:    prdata = {{16{cfg_reg.feedforward_gain[15]}},
                                      cfg_reg.feedforward_gain};
            REG_OUT_LIMIT:  prdata = {17'd0, cfg_reg.output_limit};
            REG_SEP_WINDOW: prdata = {17'd0, cfg_reg.separation_window};
            default:        prdata = '0;
        endcase
    end

    pcp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    pcp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .in_item(s_data),
        .cmd(cmd), .sts(sts), .result(m_data)
    );

endmodule
`default_nettype wire

/* sim/pitch_cascade_pid_checker.sv */
// Checker for the pitch cascade PID: watches both channels, predicts each drive
// transaction from the accepted ticks and the register writes. Depends on pcp_pkg.
`timescale 1ns / 1ps
module pitch_cascade_pid_checker
    import pcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  pcp_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  pcp_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_drives
);

    longint gain_okp, gain_oki, gain_ikp, gain_ikd, gain_ff, drive_limit, sep_window;
    longint integ_acc, last_target, last_rate;
    pcp_out_t drive_queue[$];

    assign pending_drives = drive_queue.size();

    function automatic longint sx16(logic [31:0] v);
        return longint'($signed(v[15:0]));
    endfunction

    task automatic predict_drive(pcp_in_t t);
        longint meas, tgt, rate, ticks, err, mag, outer, rerr, dterm, sum, raw;
        pcp_out_t res;
        meas = longint'(t.measured_angle);
        tgt = longint'(t.target_angle);
        rate = longint'(t.rate_sample);
        ticks = longint'({48'd0, t.elapsed_ticks});
        if (ticks == 0) ticks = 1;
        err = meas - tgt;
        mag = err < 0 ? -err : err;
        if (mag < sep_window) integ_acc += err;
        else integ_acc = 0;
        if (integ_acc > INTEGRAL_MAX) integ_acc = INTEGRAL_MAX;
        if (integ_acc < INTEGRAL_MIN) integ_acc = INTEGRAL_MIN;
        outer = (err * gain_okp + integ_acc * gain_oki) / 256;
        rerr = rate - outer;
        dterm = ((last_rate - rate) * gain_ikd) / ticks;
        sum = rerr * gain_ikp + dterm + (tgt - last_target) * gain_ff;
        raw = sum / 256;
        res.saturated = 1'b0;
        if (raw > drive_limit) begin
            raw = drive_limit;
            res.saturated = 1'b1;
        end
        if (raw < -drive_limit) begin
            raw = -drive_limit;
            res.saturated = 1'b1;
        end
        res.drive = raw[15:0];
        last_target = tgt;
        last_rate = rate;
        drive_queue.push_back(res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_okp <= 0; gain_oki <= 0; gain_ikp <= 0; gain_ikd <= 0; gain_ff <= 0;
            drive_limit <= 5000; sep_window <= 600;
            integ_acc <= 0; last_target <= 0; last_rate <= 0;
            fail_count <= 0;
            drive_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_OUTER_KP:   gain_okp = sx16(pwdata);
                    REG_OUTER_KI:   gain_oki = sx16(pwdata);
                    REG_INNER_KP:   gain_ikp = sx16(pwdata);
                    REG_INNER_KD:   gain_ikd = sx16(pwdata);
                    REG_FF_GAIN:    gain_ff = sx16(pwdata);
                    REG_OUT_LIMIT:  drive_limit = longint'({49'd0, pwdata[14:0]});
                    REG_SEP_WINDOW: sep_window = longint'({49'd0, pwdata[14:0]});
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_drive(s_data);
            if (m_valid && m_ready) begin
                if (drive_queue.size() == 0) begin
                    $error("unexpected drive transaction %0d", m_data.drive);
                    fail_count <= fail_count + 1;
                end else begin
                    pcp_out_t exp_res;
                    int miss;
                    exp_res = drive_queue.pop_front();
                    miss = 0;
                    if (exp_res.drive !== m_data.drive) begin
                        $error("drive expected %0d actual %0d", exp_res.drive, m_data.drive);
                        miss++;
                    end
                    if (exp_res.saturated !== m_data.saturated) begin
                        $error("saturated expected %0d actual %0d",
                               exp_res.saturated, m_data.saturated);
                        miss++;
                    end
                    fail_count <= fail_count + miss;
                end
            end
        end
    end

endmodule

/* sim/pitch_cascade_pid_tb.sv */
// Testbench top for the pitch cascade PID: drives control ticks, register writes
// and result back-pressure. Depends on pcp_pkg, pitch_cascade_pid and its checker.
`timescale 1ns / 1ps
module pitch_cascade_pid_tb;
    import pcp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    pcp_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    pcp_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_drives;
    bit          hold_off = 1'b0;
    bit          sender_done = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    pitch_cascade_pid i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    pitch_cascade_pid_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending_drives
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_tick(pcp_in_t t, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g + 1) @(negedge aclk);
        s_data <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_drives != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7fff;
        if (r == 1) return 16'h8000;
        if (r < 5) return 16'($urandom_range(0, 600)) - 16'd300;
        return 16'($urandom);
    endfunction

    function automatic pcp_in_t rand_tick(logic [15:0] base);
        pcp_in_t t;
        int r;
        r = $urandom_range(0, 9);
        t.target_angle = (r < 6) ? base + 16'($urandom_range(0, 40)) - 16'd20 : rand_word();
        t.measured_angle = (r < 7) ? t.target_angle + 16'($urandom_range(0, 1400)) - 16'd700
                                   : rand_word();
        t.rate_sample = rand_word();
        r = $urandom_range(0, 9);
        t.elapsed_ticks = (r == 0) ? 16'd0 : (r < 7) ? 16'($urandom_range(1, 8)) : 16'($urandom);
        return t;
    endfunction

    task automatic random_config();
        logic [2:0] idx;
        for (int i = 0; i < 7; i++) begin
            idx = 3'(i);
            if (i < 5) write_reg(idx, (($urandom_range(0, 5) == 0) ? $urandom
                                       : 32'($urandom_range(0, 1024)) - 32'd512));
            else write_reg(idx, ($urandom_range(0, 4) == 0) ? $urandom
                                 : 32'($urandom_range(0, 3000)));
        end
    endtask

    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end else if (sender_done || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                g = gap_len();
                m_ready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
        end
    end

    initial begin
        pcp_in_t t;
        logic [15:0] base;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults first, then extremes with all gains but inner_kp at full scale
        send_tick('{16'h7fff, 16'h8000, 16'h7fff, 16'd0}, 0);
        send_tick('{16'h8000, 16'h7fff, 16'h8000, 16'hffff}, 0);
        drain();
        write_reg(REG_OUTER_KP, 32'h0000_7fff);
        write_reg(REG_OUTER_KI, 32'h0000_8000);
        write_reg(REG_INNER_KP, 32'h0000_0100);
        write_reg(REG_INNER_KD, 32'h0000_7fff);
        write_reg(REG_FF_GAIN, 32'h0000_8000);
        write_reg(REG_OUT_LIMIT, 32'h0000_7fff);
        write_reg(REG_SEP_WINDOW, 32'h0000_0000);
        send_tick('{16'h0010, 16'h0000, 16'h1234, 16'd0}, 0);
        send_tick('{16'h8000, 16'h7fff, 16'h8000, 16'd1}, 0);
        send_tick('{16'h7fff, 16'h8000, 16'h7fff, 16'hffff}, 0);
        drain();
        write_reg(REG_OUT_LIMIT, 32'h0000_0000);
        write_reg(REG_SEP_WINDOW, 32'h0000_7fff);
        write_reg(3'd7, 32'h0000_1111);
        for (int i = 0; i < 6; i++) send_tick('{16'(i * 500), 16'h0000, 16'(i * 7), 16'(i)}, 0);
        send_tick('{16'h0000, 16'h0000, 16'h0000, 16'd3}, 0);
        drain();
        write_reg(REG_OUT_LIMIT, 32'h0000_1388);
        write_reg(REG_SEP_WINDOW, 32'h0000_0258);
        write_reg(REG_OUTER_KI, 32'h0000_0040);
        for (int i = 0; i < 8; i++) send_tick('{16'd550, 16'd0, 16'd0, 16'd1}, 0);
        for (int i = 0; i < 6; i++) send_tick('{-16'sd500, 16'd0, 16'd0, 16'd1}, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            base = rand_word();
            if (ph == 2) hold_off = 1'b1;
            for (int i = 0; i < 125; i++) begin
                t = rand_tick(base);
                base = t.target_angle;
                send_tick(t, (ph % 3) != 1);
            end
            drain();
        end
        sender_done = 1'b1;
        drain();
        if (fail_count == 0) begin
            $display("pitch_cascade_pid test passed");
        end else begin
            $display("pitch_cascade_pid test failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("pitch_cascade_pid test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/pcp_pkg.sv
sv/pcp_datapath.sv
sv/pcp_ctrl.sv
sv/pitch_cascade_pid.sv
sim/pitch_cascade_pid_checker.sv
sim/pitch_cascade_pid_tb.sv
